// ----- hw/rtl/raid5_access_planner_defines.svh -----
// ---------------------------------------------------------------------------
// raid5_access_planner_defines
// Assertion macros shared by the planner modules.
// ---------------------------------------------------------------------------
`ifndef RAID5_ACCESS_PLANNER_DEFINES_SVH
`define RAID5_ACCESS_PLANNER_DEFINES_SVH

`ifndef SYNTH
`define RAP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RAP_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define RAP_ASSERT(label, clk, rst_n, prop, msg)
`define RAP_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

// ----- hw/rtl/rap_pkg.sv -----
// ---------------------------------------------------------------------------
// rap_pkg
// Types and constants of the RAID 5 access planner.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rap_pkg;

    localparam int MAX_DISKS = 16;
    localparam int SEC_W     = 25;
    localparam int OFF_W     = 21;

    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_FAIL  = 2'd2;
    localparam logic [1:0] REQ_REBLD = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DEG  = 2'd1;
    localparam logic [1:0] ST_FAIL = 2'd2;

    localparam logic [2:0] K_NONE    = 3'd0;
    localparam logic [2:0] K_RD_HOST = 3'd1;
    localparam logic [2:0] K_RD_A    = 3'd2;
    localparam logic [2:0] K_RD_B    = 3'd3;
    localparam logic [2:0] K_WR_DATA = 3'd4;
    localparam logic [2:0] K_WR_AD   = 3'd5;
    localparam logic [2:0] K_WR_ABD  = 3'd6;
    localparam logic [2:0] K_DELIVER = 3'd7;

    localparam logic [4:0] NO_DISK = 5'(MAX_DISKS);

    localparam logic [1:0] SEL_RDA = 2'd0;
    localparam logic [1:0] SEL_RDB = 2'd1;
    localparam logic [1:0] SEL_MID = 2'd2;
    localparam logic [1:0] SEL_FIN = 2'd3;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [SEC_W-1:0] sector;
        logic [3:0]       fault_device;
        logic             last_in_request;
    } t_in;

    typedef struct packed {
        logic [2:0]       cmd_kind;
        logic [3:0]       device;
        logic [OFF_W-1:0] offset;
        logic [1:0]       array_status;
        logic [4:0]       failed_disk;
        logic             request_end;
        logic             last;
    } t_out;

    typedef struct packed {
        logic       load_in;
        logic       div_start;
        logic       div_sel;
        logic       div_step;
        logic       apply_event;
        logic       scan_clr;
        logic       scan_inc;
        logic       emit;
        logic [1:0] emit_sel;
    } t_cmd;

    typedef struct packed {
        logic is_event;
        logic div_last;
        logic scan_end;
        logic excl_a;
        logic excl_b;
        logic out_free;
        logic use_a;
        logic use_b;
        logic use_mid;
    } t_sts;

endpackage

// ----- hw/rtl/rap_dp.sv -----
// ---------------------------------------------------------------------------
// rap_dp
// Datapath: array state, serial divider, stripe mapping, device scan and
// output word register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "raid5_access_planner_defines.svh"

module rap_dp
    import rap_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in        i_in,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_data,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out       o_out
);

    logic [4:0]       r_n;
    logic [1:0]       r_state;
    logic [4:0]       r_fi;
    t_in              r_in;
    logic [SEC_W-1:0] r_quo;
    logic [4:0]       r_rem;
    logic [4:0]       r_dvs;
    logic [4:0]       r_dcnt;
    logic [SEC_W-1:0] r_row;
    logic [3:0]       r_col;
    logic [3:0]       r_d;
    logic             r_out_valid;
    t_out             r_out;

    logic [5:0] div_t;
    logic       div_ge;
    logic [5:0] div_diff;
    logic [3:0] pd;
    logic [3:0] dd;
    logic       acc_ok, deg, rd, wr, fi_pd, fi_dd, rd_rec, a_excl_fi;
    logic       d_fi, d_dd, d_pd;
    t_out       w_out;
    logic [4:0] cfg_n;

    assign div_t    = {r_rem, r_quo[SEC_W-1]};
    assign div_ge   = div_t >= {1'b0, r_dvs};
    assign div_diff = div_t - {1'b0, r_dvs};

    assign pd     = r_rem[3:0];
    assign dd     = r_col + ((r_col >= pd) ? 4'd1 : 4'd0);
    assign acc_ok = (r_state != ST_FAIL) && (r_row[SEC_W-1:OFF_W] == '0);
    assign deg    = r_state == ST_DEG;
    assign rd     = r_in.req_type == REQ_READ;
    assign wr     = r_in.req_type == REQ_WRITE;
    assign fi_pd  = r_fi == {1'b0, pd};
    assign fi_dd  = r_fi == {1'b0, dd};
    assign rd_rec = rd && deg && fi_dd;
    assign a_excl_fi = rd_rec || (wr && deg && !fi_pd && !fi_dd);

    assign d_fi = r_fi == {1'b0, r_d};
    assign d_dd = r_d == dd;
    assign d_pd = r_d == pd;

    always_comb begin
        o_sts.is_event = i_in.req_type[1];
        o_sts.div_last = r_dcnt == 5'(SEC_W - 1);
        o_sts.scan_end = {1'b0, r_d} == (r_n - 5'd1);
        o_sts.excl_a   = a_excl_fi ? d_fi : (d_dd || d_pd);
        o_sts.excl_b   = d_fi || d_dd || d_pd;
        o_sts.out_free = !r_out_valid || i_out_ready;
        o_sts.use_a    = acc_ok && (rd_rec || (wr && !(deg && fi_pd)));
        o_sts.use_b    = acc_ok && wr && deg && !fi_pd && !fi_dd;
        o_sts.use_mid  = acc_ok && wr && (!deg || (!fi_pd && !fi_dd));
    end

    always_comb begin
        w_out              = '0;
        w_out.array_status = r_state;
        w_out.failed_disk  = r_fi;
        w_out.offset       = r_row[OFF_W-1:0];
        case (i_cmd.emit_sel)
            SEL_RDA: begin
                w_out.cmd_kind = K_RD_A;
                w_out.device   = r_d;
            end
            SEL_RDB: begin
                w_out.cmd_kind = K_RD_B;
                w_out.device   = r_d;
            end
            SEL_MID: begin
                w_out.cmd_kind = K_WR_DATA;
                w_out.device   = dd;
            end
            default: begin
                w_out.last        = 1'b1;
                w_out.request_end = !r_in.req_type[1] && r_in.last_in_request;
                if (r_in.req_type[1] || !acc_ok) begin
                    w_out.cmd_kind = K_NONE;
                    w_out.offset   = '0;
                end else if (rd) begin
                    w_out.cmd_kind = rd_rec ? K_DELIVER : K_RD_HOST;
                    w_out.device   = rd_rec ? r_fi[3:0] : dd;
                end else if (deg && fi_pd) begin
                    w_out.cmd_kind = K_WR_DATA;
                    w_out.device   = dd;
                end else begin
                    w_out.cmd_kind = (deg && !fi_dd) ? K_WR_ABD : K_WR_AD;
                    w_out.device   = pd;
                end
            end
        endcase
    end

    assign cfg_n = (i_cfg_data < 5'd3) ? 5'd3 :
                   (i_cfg_data > NO_DISK) ? NO_DISK : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n         <= 5'd3;
            r_state     <= ST_OK;
            r_fi        <= NO_DISK;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_n     <= cfg_n;
                r_state <= ST_OK;
                r_fi    <= NO_DISK;
            end else if (i_cmd.apply_event) begin
                if (r_in.req_type == REQ_FAIL) begin
                    if ({1'b0, r_in.fault_device} < r_n) begin
                        if (r_state == ST_OK) begin
                            r_state <= ST_DEG;
                            r_fi    <= {1'b0, r_in.fault_device};
                        end else if (deg && r_fi != {1'b0, r_in.fault_device}) begin
                            r_state <= ST_FAIL;
                        end
                    end
                end else if (deg) begin
                    r_state <= ST_OK;
                    r_fi    <= NO_DISK;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in;
        end
        if (i_cmd.div_start) begin
            r_rem  <= '0;
            r_dcnt <= '0;
            if (i_cmd.div_sel) begin
                r_dvs <= r_n;
                r_row <= r_quo;
                r_col <= r_rem[3:0];
            end else begin
                r_dvs <= r_n - 5'd1;
                r_quo <= i_in.sector;
            end
        end else if (i_cmd.div_step) begin
            r_rem  <= div_ge ? div_diff[4:0] : div_t[4:0];
            r_quo  <= {r_quo[SEC_W-2:0], div_ge};
            r_dcnt <= r_dcnt + 5'd1;
        end
        if (i_cmd.scan_clr) begin
            r_d <= '0;
        end else if (i_cmd.scan_inc) begin
            r_d <= r_d + 4'd1;
        end
        if (i_cmd.emit) begin
            r_out <= w_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `RAP_ASSERT(a_ok_no_fi, i_clk, i_rst_n, (r_state == ST_OK) |-> (r_fi == NO_DISK), "ok with failed disk")
    `RAP_ASSERT(a_deg_fi, i_clk, i_rst_n, (r_state != ST_OK) |-> (r_fi < r_n), "failed disk out of range")
    `RAP_NEVER(a_emit_busy, i_clk, i_rst_n, i_cmd.emit && r_out_valid && !i_out_ready, "word overwritten")

endmodule

// ----- hw/rtl/rap_ctrl.sv -----
// ---------------------------------------------------------------------------
// rap_ctrl
// Sequencer: accepts a word, applies an event or runs the two divisions and the command runs of an access.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "raid5_access_planner_defines.svh"

module rap_ctrl
    import rap_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIV1 = 4'd1;
    localparam logic [3:0] S_LAT  = 4'd2;
    localparam logic [3:0] S_DIV2 = 4'd3;
    localparam logic [3:0] S_PLAN = 4'd4;
    localparam logic [3:0] S_EVT  = 4'd5;
    localparam logic [3:0] S_RDA  = 4'd6;
    localparam logic [3:0] S_RDB  = 4'd7;
    localparam logic [3:0] S_MID  = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;

    logic [3:0] r_st;
    logic [3:0] n_st;
    logic       adv;

    assign o_in_ready = r_st == S_IDLE;

    always_comb begin
        n_st  = r_st;
        o_cmd = '0;
        adv   = 1'b0;
        case (r_st)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    if (i_sts.is_event) begin
                        n_st = S_EVT;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        n_st            = S_DIV1;
                    end
                end
            end
            S_DIV1: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_st = S_LAT;
            end
            S_LAT: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = 1'b1;
                n_st            = S_DIV2;
            end
            S_DIV2: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_st = S_PLAN;
            end
            S_PLAN: begin
                o_cmd.scan_clr = 1'b1;
                n_st = i_sts.use_a ? S_RDA : (i_sts.use_mid ? S_MID : S_FIN);
            end
            S_EVT: begin
                o_cmd.apply_event = 1'b1;
                n_st              = S_FIN;
            end
            S_RDA: begin
                o_cmd.emit_sel = SEL_RDA;
                if (i_sts.excl_a) begin
                    adv = 1'b1;
                end else if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    adv        = 1'b1;
                end
                o_cmd.scan_inc = adv;
                if (adv && i_sts.scan_end) begin
                    o_cmd.scan_clr = 1'b1;
                    n_st = i_sts.use_b ? S_RDB : (i_sts.use_mid ? S_MID : S_FIN);
                end
            end
            S_RDB: begin
                o_cmd.emit_sel = SEL_RDB;
                if (i_sts.excl_b) begin
                    adv = 1'b1;
                end else if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    adv        = 1'b1;
                end
                o_cmd.scan_inc = adv;
                if (adv && i_sts.scan_end) n_st = S_MID;
            end
            S_MID: begin
                o_cmd.emit_sel = SEL_MID;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_st       = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.emit_sel = SEL_FIN;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_st       = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    `RAP_ASSERT(a_emit_free, i_clk, i_rst_n, o_cmd.emit |-> i_sts.out_free, "emit while full")
    `RAP_ASSERT(a_lat_next, i_clk, i_rst_n, (r_st == S_DIV1 && i_sts.div_last) |=> (r_st == S_LAT), "divide sequencing")
    `RAP_ASSERT(a_evt_fin, i_clk, i_rst_n, (r_st == S_EVT) |=> (r_st == S_FIN), "event sequencing")

endmodule

// ----- hw/rtl/raid5_access_planner.sv -----
// ---------------------------------------------------------------------------
// raid5_access_planner
// RAID 5 rotating parity command planner: maps a sector and emits the run of
// device commands for the current array state.
// ---------------------------------------------------------------------------
// Events: a single result. Accesses: two 25-step serial divisions before the
// first result, then each read run scans all n disks, followed by the fixed
// commands; output stalls hold the scan and the commands.
// One word in flight at a time; the next word is taken after the last result.
// Synchronous active-low reset: n = 3, array ok, no failed disk.
`timescale 1ns / 1ps

module raid5_access_planner
    import rap_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in        i_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out       o_out,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    rap_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rap_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

// ----- verif/tb_raid5_access_planner.sv -----
// ---------------------------------------------------------------------------
// tb_raid5_access_planner
// Self-checking bench for the RAID 5 command planner: a behavioral planner
// predicts every command run, a checker compares each output word in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_raid5_access_planner;
    import rap_pkg::*;

    localparam int WATCHDOG = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out;
    logic i_cfg_we = 1'b0;
    logic [4:0] i_cfg_data = '0;

    always #10 i_clk = ~i_clk;

    raid5_access_planner u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    // planner state
    logic [4:0] disk_count = 5'd3;
    logic [1:0] arr_state  = ST_OK;
    logic [4:0] bad_disk   = NO_DISK;

    t_out cmd_queue[$];
    int   errors = 0;
    int   idle_pct = 0;
    int   stall_pct = 0;
    bit   hold_off = 0;
    int   quiet = 0;

    task automatic push_cmd(input logic [2:0] k, input logic [4:0] d, input logic [20:0] off);
        t_out w;
        w = '0;
        w.cmd_kind = k;
        w.device = d[3:0];
        w.offset = off;
        cmd_queue.push_back(w);
    endtask

    task automatic push_reads(input logic [2:0] k, input logic [20:0] off,
                              input int x1, input int x2, input int x3);
        for (int d = 0; d < disk_count; d++)
            if (d != x1 && d != x2 && d != x3) push_cmd(k, 5'(d), off);
    endtask

    task automatic plan_commands(input t_in w);
        int first, n, row, col, pd, dd, fi;
        bit deg;
        first = cmd_queue.size();
        n = disk_count;
        fi = bad_disk;
        deg = (arr_state == ST_DEG);
        if (w.req_type == REQ_FAIL) begin
            if (w.fault_device < n) begin
                if (arr_state == ST_OK) begin
                    arr_state = ST_DEG;
                    bad_disk = {1'b0, w.fault_device};
                end else if (deg && w.fault_device != fi) begin
                    arr_state = ST_FAIL;
                end
            end
            push_cmd(K_NONE, 5'd0, 21'd0);
        end else if (w.req_type == REQ_REBLD) begin
            if (deg) begin
                arr_state = ST_OK;
                bad_disk = NO_DISK;
            end
            push_cmd(K_NONE, 5'd0, 21'd0);
        end else begin
            row = w.sector / (n - 1);
            col = w.sector % (n - 1);
            pd = row % n;
            dd = col + (col >= pd);
            if (arr_state == ST_FAIL || row >= 2097152) begin
                push_cmd(K_NONE, 5'd0, 21'd0);
            end else if (w.req_type == REQ_READ) begin
                if (deg && dd == fi) begin
                    push_reads(K_RD_A, 21'(row), fi, MAX_DISKS, MAX_DISKS);
                    push_cmd(K_DELIVER, 5'(fi), 21'(row));
                end else begin
                    push_cmd(K_RD_HOST, 5'(dd), 21'(row));
                end
            end else if (!deg) begin
                push_reads(K_RD_A, 21'(row), dd, pd, MAX_DISKS);
                push_cmd(K_WR_DATA, 5'(dd), 21'(row));
                push_cmd(K_WR_AD, 5'(pd), 21'(row));
            end else if (fi == pd) begin
                push_cmd(K_WR_DATA, 5'(dd), 21'(row));
            end else if (fi == dd) begin
                push_reads(K_RD_A, 21'(row), dd, pd, MAX_DISKS);
                push_cmd(K_WR_AD, 5'(pd), 21'(row));
            end else begin
                push_reads(K_RD_A, 21'(row), fi, MAX_DISKS, MAX_DISKS);
                push_reads(K_RD_B, 21'(row), fi, dd, pd);
                push_cmd(K_WR_DATA, 5'(dd), 21'(row));
                push_cmd(K_WR_ABD, 5'(pd), 21'(row));
            end
        end
        for (int i = first; i < cmd_queue.size(); i++) begin
            cmd_queue[i].array_status = arr_state;
            cmd_queue[i].failed_disk = bad_disk;
            cmd_queue[i].last = (i == cmd_queue.size() - 1);
            cmd_queue[i].request_end = (i == cmd_queue.size() - 1) && w.req_type < 2
                                       && w.last_in_request;
        end
    endtask

    task automatic send_word(input t_in w);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in <= w;
        i_in_valid <= 1'b1;
        plan_commands(w);
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    function automatic t_in make_access(input logic [1:0] rt, input logic [24:0] sec);
        t_in w;
        w = '0;
        w.req_type = rt;
        w.sector = sec;
        w.last_in_request = 1'($urandom);
        w.fault_device = 4'($urandom);
        return w;
    endfunction

    function automatic t_in make_event(input logic [1:0] rt, input logic [3:0] fd);
        t_in w;
        w = make_access(rt, 25'($urandom));
        w.fault_device = fd;
        return w;
    endfunction

    task automatic drain();
        i_in_valid <= 1'b0;
        while (cmd_queue.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_disk_count(input logic [4:0] v);
        drain();
        i_cfg_data <= v;
        i_cfg_we <= 1'b1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        disk_count = (v < 3) ? 5'd3 : (v > 16) ? 5'd16 : v;
        arr_state = ST_OK;
        bad_disk = NO_DISK;
    endtask

    // checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (cmd_queue.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word %h", o_out);
            end else begin
                if (o_out !== cmd_queue[0]) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %h actual %h", cmd_queue[0], o_out);
                end
                void'(cmd_queue.pop_front());
            end
        end
    end

    always @(posedge i_clk)
        i_out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG) begin
            $display("** raid5_access_planner: FAILED **");
            $finish;
        end
    end

    task automatic test_directed();
        write_disk_count(5'd0);
        send_word(make_access(REQ_READ, 25'd0));
        send_word(make_access(REQ_WRITE, 25'd5));
        send_word(make_access(REQ_READ, 25'h1FFFFFF));
        send_word(make_access(REQ_WRITE, 25'd4194303));
        send_word(make_event(REQ_REBLD, 0));
        send_word(make_event(REQ_FAIL, 4'd15));
        send_word(make_event(REQ_FAIL, 4'd1));
        send_word(make_event(REQ_FAIL, 4'd1));
        for (int s = 0; s < 6; s++) send_word(make_access(1'(s) ? REQ_WRITE : REQ_READ, 25'(s)));
        for (int s = 0; s < 6; s++) send_word(make_access(REQ_WRITE, 25'(s)));
        send_word(make_event(REQ_FAIL, 4'd0));
        send_word(make_access(REQ_READ, 25'd0));
        send_word(make_event(REQ_REBLD, 0));
        send_word(make_event(REQ_REBLD, 0));
        write_disk_count(5'd31);
        send_word(make_access(REQ_WRITE, 25'h1FFFFFF));
        send_word(make_event(REQ_FAIL, 4'd7));
        send_word(make_access(REQ_WRITE, 25'd1234567));
    endtask

    task automatic test_random(input int count, input int ip, input int sp);
        int r;
        idle_pct = ip;
        stall_pct = sp;
        write_disk_count(5'($urandom_range(31)));
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 5)
                send_word(make_event(REQ_FAIL, 4'($urandom_range(disk_count - 1))));
            else if (r < 7)
                send_word(make_event(REQ_FAIL, 4'($urandom)));
            else if (r < 10)
                send_word(make_event(REQ_REBLD, 4'($urandom)));
            else if (r < 15)
                send_word(make_access(2'($urandom_range(1)), 25'($urandom)));
            else
                send_word(make_access(2'($urandom_range(1)),
                                      25'($urandom_range(2097151 * (disk_count - 1)))));
        end
        drain();
    endtask

    task automatic test_backpressure();
        idle_pct = 0;
        stall_pct = 0;
        hold_off = 1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                hold_off = 0;
            end
            for (int i = 0; i < 6; i++) send_word(make_access(REQ_WRITE, 25'($urandom)));
        join
        drain();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(70, 0, 0);
        test_random(70, 77, 0);
        test_random(70, 0, 77);
        test_random(50, 9, 9);
        test_random(20, 0, 0);
        test_backpressure();
        drain();
        if (errors == 0 && cmd_queue.size() == 0)
            $display("** raid5_access_planner: PASSED **");
        else
            $display("** raid5_access_planner: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/rap_pkg.sv
hw/rtl/rap_dp.sv
hw/rtl/rap_ctrl.sv
hw/rtl/raid5_access_planner.sv
verif/tb_raid5_access_planner.sv
